FILE: hdl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on an explicit clock and active-low reset.
`define ASSERT_ON(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check on the block clock and reset.
`define ASSERT_CLK(label, prop, msg) `ASSERT_ON(label, i_clk, i_rst_n, prop, msg)

`endif

FILE: hdl/scc_pkg.sv
package scc_pkg;

    localparam int NUM_DIGITS = 6;

    typedef logic [3:0] t_bcd;
    // index 0 = seconds units ... index 5 = hours tens
    typedef t_bcd [NUM_DIGITS-1:0] t_digits;

    // 23:59:50
    localparam t_digits TIME_RESET = {4'd2, 4'd3, 4'd5, 4'd9, 4'd5, 4'd0};

    localparam logic [7:0] LOW_RELOAD_RESET  = 8'd240;
    localparam logic [7:0] HIGH_RELOAD_RESET = 8'd4;

    // Digit selects whose keys do something
    localparam logic [NUM_DIGITS-1:0] SEL_MODE    = 6'b000001;
    localparam logic [NUM_DIGITS-1:0] SEL_SECONDS = 6'b000100;
    localparam logic [NUM_DIGITS-1:0] SEL_MINUTES = 6'b010000;
    localparam logic [NUM_DIGITS-1:0] SEL_HOURS   = 6'b100000;

    typedef enum logic [0:0] {
        REG_PRESCALE_LOW  = 1'b0,
        REG_PRESCALE_HIGH = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [7:0] low_reload;
        logic [7:0] high_reload;
    } t_prescale_cfg;

    typedef struct packed {
        logic [5:0] digit_select;
        logic [6:0] segments;
        logic       edit_mode;
        logic [5:0] hours_bcd;
        logic [6:0] minutes_bcd;
        logic [6:0] seconds_bcd;
    } t_result;

    // Segment pattern, bit0 = a .. bit6 = g; blank for non-decimal codes
    function automatic logic [6:0] seg_pattern(input t_bcd digit);
        logic [6:0] seg;
        case (digit)
            4'd0:    seg = 7'h3F;
            4'd1:    seg = 7'h06;
            4'd2:    seg = 7'h5B;
            4'd3:    seg = 7'h4F;
            4'd4:    seg = 7'h66;
            4'd5:    seg = 7'h6D;
            4'd6:    seg = 7'h7D;
            4'd7:    seg = 7'h07;
            4'd8:    seg = 7'h7F;
            4'd9:    seg = 7'h6F;
            default: seg = 7'h00;
        endcase
        return seg;
    endfunction

    // Hours step with 24-hour rollover
    function automatic t_digits step_hours(input t_digits d);
        t_digits r;
        r = d;
        r[4] = r[4] + 4'd1;
        if (r[4] == 4'd10) begin
            r[4] = 4'd0;
            r[5] = r[5] + 4'd1;
        end
        if (r[5] == 4'd2 && r[4] == 4'd4) begin
            r[4] = 4'd0;
            r[5] = 4'd0;
        end
        return r;
    endfunction

    function automatic t_digits step_minutes(input t_digits d, input logic carry);
        t_digits r;
        r = d;
        r[2] = r[2] + 4'd1;
        if (r[2] == 4'd10) begin
            r[2] = 4'd0;
            r[3] = r[3] + 4'd1;
        end
        if (r[3] == 4'd6) begin
            r[3] = 4'd0;
            if (carry) begin
                r = step_hours(r);
            end
        end
        return r;
    endfunction

    function automatic t_digits step_seconds(input t_digits d, input logic carry);
        t_digits r;
        r = d;
        r[0] = r[0] + 4'd1;
        if (r[0] == 4'd10) begin
            r[0] = 4'd0;
            r[1] = r[1] + 4'd1;
        end
        if (r[1] == 4'd6) begin
            r[1] = 4'd0;
            if (carry) begin
                r = step_minutes(r, 1'b1);
            end
        end
        return r;
    endfunction

endpackage

FILE: hdl/scc_if.sv
// Scan tick request channel
interface scc_in_if;
    logic valid;
    logic ready;
    logic key_line;

    modport source (output valid, output key_line, input ready);
    modport sink   (input valid, input key_line, output ready);
endinterface

// Display result channel
interface scc_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] digit_select;
    logic [6:0] segments;
    logic       edit_mode;
    logic [5:0] hours_bcd;
    logic [6:0] minutes_bcd;
    logic [6:0] seconds_bcd;

    modport source (output valid, output digit_select, output segments, output edit_mode,
                    output hours_bcd, output minutes_bcd, output seconds_bcd, input ready);
    modport sink   (input valid, input digit_select, input segments, input edit_mode,
                    input hours_bcd, input minutes_bcd, input seconds_bcd, output ready);
endinterface

// Register write channel
interface scc_cfg_if;
    logic       valid;
    logic       ready;
    logic [0:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/scc_prescaler.sv
module scc_prescaler (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_advance,
    input  logic                  i_run,
    input  scc_pkg::t_prescale_cfg i_cfg,
    output logic                  o_second
);
    import scc_pkg::*;

    logic [7:0] r_fast, n_fast;
    logic [7:0] r_slow, n_slow;

    // Two-stage countdown; a second elapses when the slow stage hits zero
    always_comb begin
        n_fast = r_fast;
        n_slow = r_slow;
        if (r_fast != 8'd0) begin
            n_fast = r_fast - 8'd1;
        end else begin
            n_slow = r_slow - 8'd1;
            n_fast = i_cfg.low_reload;
        end
        o_second = i_run && (n_slow == 8'd0);
        if (n_slow == 8'd0) begin
            n_fast = i_cfg.low_reload;
            n_slow = i_cfg.high_reload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast <= LOW_RELOAD_RESET;
            r_slow <= HIGH_RELOAD_RESET;
        end else if (i_advance && i_run) begin
            r_fast <= n_fast;
            r_slow <= n_slow;
        end
    end

endmodule

FILE: hdl/scc_core.sv
module scc_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_advance,
    input  logic             i_key_line,
    input  logic             i_second,
    output logic             o_run,
    output scc_pkg::t_result o_result
);
    import scc_pkg::*;

    `include "assert_macros.svh"

    t_digits               r_digits, n_digits;
    logic [2:0]            r_scan, n_scan;
    logic [NUM_DIGITS-1:0] r_held, n_held;
    logic                  r_latched, n_latched;
    logic                  r_mode, n_mode;

    logic [2:0]            pos;
    logic [NUM_DIGITS-1:0] sel;
    t_digits               key_digits;

    // Drive digit, handle key, advance scan
    always_comb begin
        pos        = (r_scan >= 3'(NUM_DIGITS)) ? 3'd0 : r_scan;
        sel        = NUM_DIGITS'(1) << pos;
        n_held     = r_held;
        n_latched  = r_latched;
        n_mode     = r_mode;
        key_digits = r_digits;

        if (i_key_line) begin
            n_held = sel;
            if (!r_latched) begin
                case (sel)
                    SEL_MODE: begin
                        n_mode    = !r_mode;
                        n_latched = 1'b1;
                    end
                    SEL_SECONDS: begin
                        if (r_mode) begin
                            key_digits = step_seconds(r_digits, 1'b0);
                            n_latched  = 1'b1;
                        end
                    end
                    SEL_MINUTES: begin
                        if (r_mode) begin
                            key_digits = step_minutes(r_digits, 1'b0);
                            n_latched  = 1'b1;
                        end
                    end
                    SEL_HOURS: begin
                        if (r_mode) begin
                            key_digits = step_hours(r_digits);
                            n_latched  = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end else if (sel == r_held && r_latched) begin
            n_latched = 1'b0;
        end

        n_scan = (pos == 3'(NUM_DIGITS - 1)) ? 3'd0 : pos + 3'd1;
        o_run  = !n_mode;

        // Running clock: one second with full carry
        n_digits = i_second ? step_seconds(key_digits, 1'b1) : key_digits;
    end

    // Result fields
    always_comb begin
        o_result.digit_select = sel;
        o_result.segments     = seg_pattern(r_digits[pos]);
        o_result.edit_mode    = n_mode;
        o_result.hours_bcd    = {n_digits[5][1:0], n_digits[4]};
        o_result.minutes_bcd  = {n_digits[3][2:0], n_digits[2]};
        o_result.seconds_bcd  = {n_digits[1][2:0], n_digits[0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digits  <= TIME_RESET;
            r_scan    <= 3'd0;
            r_held    <= '0;
            r_latched <= 1'b0;
            r_mode    <= 1'b0;
        end else if (i_advance) begin
            r_digits  <= n_digits;
            r_scan    <= n_scan;
            r_held    <= n_held;
            r_latched <= n_latched;
            r_mode    <= n_mode;
        end
    end

    `ASSERT_CLK(a_scan_range, r_scan < 3'(NUM_DIGITS), "scan position out of range")
    `ASSERT_CLK(a_latch_onehot, r_latched |-> $onehot(r_held), "latched key without one digit")
    `ASSERT_CLK(a_mode_hold, !i_advance |=> $stable(r_mode), "edit mode changed without a tick")
    `ASSERT_CLK(a_sec_bcd, r_digits[0] <= 4'd9 && r_digits[1] <= 4'd5, "seconds not valid BCD")

endmodule

FILE: hdl/settable_clock_scan_controller.sv
// Settable 24-hour clock driving a six-digit multiplexed seven-segment display.
// i_req carries one scan tick per request with the sampled key return line.
// o_rsp returns, for every tick, the one-hot digit select, its segment
// pattern, the edit flag and the packed BCD time after that tick.
// i_cfg writes the prescaler reloads: index 0 fast stage, index 1 slow stage
// (one second every (low+1)*high ticks); new values apply at the next reload.
// A tick lands in the input register, and its result is registered in the
// output register when the tick advances, which sets o_rsp.valid.
// Throughput: one tick per cycle while o_rsp is not stalled; all digit stepping
// and the segment lookup sit in one combinational pass between the two registers.
// A stalled o_rsp holds its result; one more tick is then held in the input
// register and i_req.ready falls until the result is taken.
// Reset (synchronous, active low) sets 23:59:50, scan position 0, edit mode
// off, reloads 240 and 4, and empties both registers. i_cfg is always ready.
module settable_clock_scan_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    scc_in_if.sink      i_req,
    scc_out_if.source   o_rsp,
    scc_cfg_if.sink     i_cfg
);
    import scc_pkg::*;

    logic          r_in_valid;
    logic          r_key;
    logic          r_out_valid;
    t_result       r_out;
    t_result       result;
    t_prescale_cfg r_cfg;
    logic          advance;
    logic          run;
    logic          second;

    assign advance     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.low_reload  <= LOW_RELOAD_RESET;
            r_cfg.high_reload <= HIGH_RELOAD_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_PRESCALE_LOW:  r_cfg.low_reload  <= i_cfg.data;
                REG_PRESCALE_HIGH: r_cfg.high_reload <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.valid && i_req.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_key <= i_req.key_line;
        end
    end

    scc_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (advance),
        .i_key_line (r_key),
        .i_second   (second),
        .o_run      (run),
        .o_result   (result)
    );

    scc_prescaler u_prescaler (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_run     (run),
        .i_cfg     (r_cfg),
        .o_second  (second)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.digit_select = r_out.digit_select;
    assign o_rsp.segments     = r_out.segments;
    assign o_rsp.edit_mode    = r_out.edit_mode;
    assign o_rsp.hours_bcd    = r_out.hours_bcd;
    assign o_rsp.minutes_bcd  = r_out.minutes_bcd;
    assign o_rsp.seconds_bcd  = r_out.seconds_bcd;

endmodule

FILE: bench/scc_checker.sv
`timescale 1ns / 1ps

// Watches the tick, display and register channels of the scan controller,
// keeps its own copy of the clock state and checks every display request.
module scc_checker
    import scc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    scc_in_if    i_req,
    scc_out_if   i_rsp,
    scc_cfg_if   i_cfg,
    output int   o_mismatches,
    output int   o_pending
);

    // Segment font, bit0 = a .. bit6 = g; codes above 9 are blank
    localparam logic [6:0] SEG_FONT [16] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07,
        7'h7F, 7'h6F, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

    // Shadow of the clock state
    t_digits       clock_digits;
    logic [2:0]    scan_pos;
    logic [5:0]    held_sel;
    logic          key_held;
    logic          setting;
    logic [7:0]    fast_left;
    logic [7:0]    slow_left;
    t_prescale_cfg reloads;

    // Display requests still owed by the block, oldest first
    t_result display_q [$];

    // Advance a units/tens pair; returns 1 when the tens wrap to zero
    function automatic bit bump_pair(input int lo, input logic [3:0] tens_wrap);
        clock_digits[lo] = clock_digits[lo] + 4'd1;
        if (clock_digits[lo] == 4'd10) begin
            clock_digits[lo]     = 4'd0;
            clock_digits[lo + 1] = clock_digits[lo + 1] + 4'd1;
        end
        if (clock_digits[lo + 1] == tens_wrap) begin
            clock_digits[lo + 1] = 4'd0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Hours roll from 23 to 00
    function automatic void bump_hours();
        clock_digits[4] = clock_digits[4] + 4'd1;
        if (clock_digits[4] == 4'd10) begin
            clock_digits[4] = 4'd0;
            clock_digits[5] = clock_digits[5] + 4'd1;
        end
        if (clock_digits[5] == 4'd2 && clock_digits[4] == 4'd4) begin
            clock_digits[4] = 4'd0;
            clock_digits[5] = 4'd0;
        end
    endfunction

    function automatic void bump_minutes(input bit carry);
        if (bump_pair(2, 4'd6) && carry) begin
            bump_hours();
        end
    endfunction

    function automatic void bump_seconds(input bit carry);
        if (bump_pair(0, 4'd6) && carry) begin
            bump_minutes(1'b1);
        end
    endfunction

    // One scan tick: drive digit, handle key, advance scan, run prescaler
    function automatic t_result next_display(input logic key);
        t_result    r;
        logic [5:0] sel;
        sel = 6'b000001 << scan_pos;
        r.digit_select = sel;
        r.segments     = SEG_FONT[clock_digits[scan_pos]];

        if (key) begin
            held_sel = sel;
            if (!key_held) begin
                case (sel)
                    SEL_MODE: begin
                        setting  = !setting;
                        key_held = 1'b1;
                    end
                    SEL_SECONDS: if (setting) begin
                        bump_seconds(1'b0);
                        key_held = 1'b1;
                    end
                    SEL_MINUTES: if (setting) begin
                        bump_minutes(1'b0);
                        key_held = 1'b1;
                    end
                    SEL_HOURS: if (setting) begin
                        bump_hours();
                        key_held = 1'b1;
                    end
                    default: ;
                endcase
            end
        end else if (sel == held_sel && key_held) begin
            key_held = 1'b0;
        end

        scan_pos = (scan_pos == 3'(NUM_DIGITS - 1)) ? 3'd0 : scan_pos + 3'd1;

        // Clock is frozen while being set
        if (!setting) begin
            if (fast_left != 8'd0) begin
                fast_left = fast_left - 8'd1;
            end else begin
                slow_left = slow_left - 8'd1;
                fast_left = reloads.low_reload;
            end
            if (slow_left == 8'd0) begin
                fast_left = reloads.low_reload;
                slow_left = reloads.high_reload;
                bump_seconds(1'b1);
            end
        end

        r.edit_mode   = setting;
        r.hours_bcd   = {clock_digits[5][1:0], clock_digits[4]};
        r.minutes_bcd = {clock_digits[3][2:0], clock_digits[2]};
        r.seconds_bcd = {clock_digits[1][2:0], clock_digits[0]};
        return r;
    endfunction

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            o_mismatches++;
        end
    endtask

    // Compare results, track register writes, predict new requests
    always @(posedge i_clk) begin : track
        t_result want;
        if (!i_rst_n) begin
            clock_digits = TIME_RESET;
            scan_pos     = 3'd0;
            held_sel     = 6'd0;
            key_held     = 1'b0;
            setting      = 1'b0;
            reloads      = '{low_reload: LOW_RELOAD_RESET, high_reload: HIGH_RELOAD_RESET};
            fast_left    = LOW_RELOAD_RESET;
            slow_left    = HIGH_RELOAD_RESET;
            display_q.delete();
            o_mismatches = 0;
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (display_q.size() == 0) begin
                    $error("display request with nothing outstanding");
                    o_mismatches++;
                end else begin
                    want = display_q.pop_front();
                    check_field("digit_select", want.digit_select, i_rsp.digit_select);
                    check_field("segments", want.segments, i_rsp.segments);
                    check_field("edit_mode", want.edit_mode, i_rsp.edit_mode);
                    check_field("hours_bcd", want.hours_bcd, i_rsp.hours_bcd);
                    check_field("minutes_bcd", want.minutes_bcd, i_rsp.minutes_bcd);
                    check_field("seconds_bcd", want.seconds_bcd, i_rsp.seconds_bcd);
                end
            end
            // new reloads only apply at the next counter reload
            if (i_cfg.valid && i_cfg.ready) begin
                case (t_reg_idx'(i_cfg.index))
                    REG_PRESCALE_LOW:  reloads.low_reload  = i_cfg.data;
                    REG_PRESCALE_HIGH: reloads.high_reload = i_cfg.data;
                    default: ;
                endcase
            end
            if (i_req.valid && i_req.ready) begin
                display_q.push_back(next_display(i_req.key_line));
            end
        end
        o_pending = display_q.size();
    end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import scc_pkg::*;

    // Scan positions of the keys
    localparam int KEY_MODE     = 0;
    localparam int KEY_SEC_TENS = 1;
    localparam int KEY_SECONDS  = 2;
    localparam int KEY_MIN_TENS = 3;
    localparam int KEY_MINUTES  = 4;
    localparam int KEY_HOURS    = 5;

    // Quiet cycles allowed: worst sender gap plus worst stall plus pipeline, many times
    localparam int STALL_LIMIT = 1000;

    logic i_clk;
    logic i_rst_n;
    int   mismatches;
    int   pending;
    int   tick_count;
    int   idle_cycles;
    bit   quiet_in;
    bit   quiet_out;

    scc_in_if  req_if ();
    scc_out_if rsp_if ();
    scc_cfg_if cfg_if ();

    settable_clock_scan_controller uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    scc_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_if),
        .i_rsp        (rsp_if),
        .i_cfg        (cfg_if),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    // 4 ns clock
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Watchdog on cycles with no request moving on any channel
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
            (cfg_if.valid && cfg_if.ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Display side: random stall before taking each request
    initial begin : display_taker
        int stall;
        rsp_if.ready = 1'b0;
        forever begin
            if ($urandom_range(0, 39) == 0) begin
                quiet_out = !quiet_out;
            end
            stall = quiet_out ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                @(negedge i_clk) rsp_if.ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk) rsp_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(rsp_if.valid && rsp_if.ready));
        end
    end

    // One scan tick request after a random gap
    task automatic send_tick(input logic key);
        int gap;
        if ($urandom_range(0, 39) == 0) begin
            quiet_in = !quiet_in;
        end
        gap = quiet_in ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            @(negedge i_clk) req_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        req_if.valid    <= 1'b1;
        req_if.key_line <= key;
        do @(posedge i_clk); while (!(req_if.valid && req_if.ready));
        tick_count++;
    endtask

    // Idle ticks until the next tick lands on the given digit
    task automatic move_to(input int digit);
        while (tick_count % NUM_DIGITS != digit) begin
            send_tick(1'b0);
        end
    endtask

    // Press a key for some scans, then let it go on its own digit
    task automatic tap(input int digit, input int scans);
        repeat (scans) begin
            move_to(digit);
            send_tick(1'b1);
        end
        move_to(digit);
        send_tick(1'b0);
    endtask

    // One full scan, bit i for digit i
    task automatic send_scan(input logic [5:0] keys);
        for (int i = 0; i < NUM_DIGITS; i++) begin
            send_tick(keys[i]);
        end
    endtask

    // Stray key pulses, optionally keeping off the mode key
    task automatic noise(input int ticks, input bit allow_mode);
        logic key;
        repeat (ticks) begin
            key = ($urandom_range(0, 3) == 0);
            if (!allow_mode && tick_count % NUM_DIGITS == KEY_MODE) begin
                key = 1'b0;
            end
            send_tick(key);
        end
    endtask

    // Mostly proper key presses with random timing, some junk
    task automatic run_mixed(input int ticks);
        int stop_at;
        int digit;
        stop_at = tick_count + ticks;
        while (tick_count < stop_at) begin
            case ($urandom_range(0, 9))
                0, 1: tap(KEY_MODE, $urandom_range(1, 2));
                2, 3, 4, 5, 6: begin
                    case ($urandom_range(0, 2))
                        0:       digit = KEY_SECONDS;
                        1:       digit = KEY_MINUTES;
                        default: digit = KEY_HOURS;
                    endcase
                    tap(digit, $urandom_range(1, 3));
                end
                7: tap($urandom_range(0, 1) ? KEY_SEC_TENS : KEY_MIN_TENS, 1);
                8: noise($urandom_range(1, 12), 1'b1);
                default: begin
                    // press one key, then jump to another without letting go
                    move_to($urandom_range(0, NUM_DIGITS - 1));
                    send_tick(1'b1);
                    tap($urandom_range(0, NUM_DIGITS - 1), 1);
                end
            endcase
        end
    endtask

    // Stop ticking and wait for every display request to come back
    task automatic drain();
        @(negedge i_clk) req_if.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [7:0] value);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!(cfg_if.valid && cfg_if.ready));
        @(negedge i_clk) cfg_if.valid <= 1'b0;
    endtask

    task automatic set_prescale(input logic [7:0] low, input logic [7:0] high);
        drain();
        write_reg(REG_PRESCALE_LOW, low);
        write_reg(REG_PRESCALE_HIGH, high);
    endtask

    // Stimulus and verdict
    initial begin
        i_rst_n         = 1'b0;
        req_if.valid    = 1'b0;
        req_if.key_line = 1'b0;
        cfg_if.valid    = 1'b0;
        cfg_if.index    = REG_PRESCALE_LOW;
        cfg_if.data     = 8'd0;
        tick_count      = 0;
        quiet_in        = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: edit on, step each unit, dead key while latched, edit off
        send_scan(6'b000001);
        send_scan(6'b001100);
        send_scan(6'b010000);
        send_scan(6'b100000);
        send_scan(6'b000000);
        send_tick(1'b1);

        // Fastest prescale; the counts left from reset must run out first,
        // then one second passes on every running tick
        set_prescale(8'd0, 8'd1);
        noise(250, 1'b0);
        run_mixed(120);

        set_prescale(8'd7, 8'd3);
        run_mixed(60);

        // zero reloads wrap: 256 ticks per second
        set_prescale(8'd0, 8'd0);
        run_mixed(30);

        set_prescale(8'd255, 8'd255);
        run_mixed(20);

        drain();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
